// ===== design/lscs_pkg.sv =====
`timescale 1ns / 1ps
package lscs_pkg;

  // Configuration port
  localparam int REG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURV_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GRADIENT = 2'd3;

  localparam logic [REG_W-1:0] INV_DX_RESET  = 32'd65536;
  localparam logic [REG_W-1:0] MAX_CURV_RESET = 32'd65536;
  localparam logic [REG_W-1:0] MIN_GRAD_RESET = 32'd1;

  // Datapath widths
  localparam int DERIV_W = 32;   // Q16.16 derivatives
  localparam int K_W     = 64;   // scale factors (a reciprocal or a product of two reciprocals)
  localparam int RAD_W   = 64;   // squared gradient magnitude
  localparam int ROOT_W  = 32;   // gradient magnitude, also the divisor width
  localparam int NRM_W   = 31;   // unit normal component, Q1.30 magnitude
  localparam int CURV_W  = 32;

endpackage

// ===== design/lscs_if.sv =====
`timescale 1ns / 1ps
interface lscs_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] phi_center;
  logic signed [SAMPLE_BITS-1:0] phi_east;
  logic signed [SAMPLE_BITS-1:0] phi_west;
  logic signed [SAMPLE_BITS-1:0] phi_north;
  logic signed [SAMPLE_BITS-1:0] phi_south;
  logic signed [SAMPLE_BITS-1:0] phi_northeast;
  logic signed [SAMPLE_BITS-1:0] phi_southeast;
  logic signed [SAMPLE_BITS-1:0] phi_northwest;
  logic signed [SAMPLE_BITS-1:0] phi_southwest;

  modport source (
    output valid, phi_center, phi_east, phi_west, phi_north, phi_south,
           phi_northeast, phi_southeast, phi_northwest, phi_southwest,
    input  ready
  );
  modport sink (
    input  valid, phi_center, phi_east, phi_west, phi_north, phi_south,
           phi_northeast, phi_southeast, phi_northwest, phi_southwest,
    output ready
  );
endinterface

interface lscs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curvature_out;
  logic               flat_gradient;

  modport source (output valid, curvature_out, flat_gradient, input ready);
  modport sink (input valid, curvature_out, flat_gradient, output ready);
endinterface

// ===== design/lscs_scale.sv =====
`timescale 1ns / 1ps
module lscs_scale #(
  parameter int D_W   = 26,
  parameter int SHIFT = 17
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [D_W-1:0]                 d,
  input  logic [lscs_pkg::K_W-1:0]              k,
  output logic signed [lscs_pkg::DERIV_W-1:0]   q
);
  import lscs_pkg::*;

  localparam int P_W = D_W + 32;
  localparam int F_W = D_W + K_W;

  logic [D_W-1:0] mag;
  logic           neg;
  logic [P_W-1:0] plo;
  logic [P_W-1:0] phi;
  logic [F_W-1:0] full;
  logic [F_W-1:0] shifted;
  logic [31:0]    m;

  assign mag = d[D_W-1] ? D_W'(-d) : d;

  // First stage: two partial products against the low and high halves of k.
  always_ff @(posedge clk) begin
    if (en) begin
      neg <= d[D_W-1];
      plo <= mag * k[31:0];
      phi <= mag * k[K_W-1:32];
    end
  end

  assign full    = {phi, 32'b0} + F_W'(plo);
  assign shifted = full >> SHIFT;
  assign m       = (shifted > F_W'(33'h0_8000_0000)) ? 32'h8000_0000 : shifted[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg) begin
        q <= DERIV_W'(32'd0 - m);
      end else begin
        q <= m[31] ? 32'h7fff_ffff : m;
      end
    end
  end

endmodule

// ===== design/lscs_isqrt.sv =====
`timescale 1ns / 1ps
module lscs_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [lscs_pkg::RAD_W-1:0]    radicand,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          valid_out,
  output logic [lscs_pkg::ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]             side_out
);
  import lscs_pkg::*;

  // Two result bits per stage, digit-by-digit square root.
  localparam int NSTG  = ROOT_W / 2;
  localparam int REM_W = ROOT_W + 2;

  logic              vld  [NSTG];
  logic [REM_W-1:0]  rem  [NSTG];
  logic [ROOT_W-1:0] rt   [NSTG];
  logic [RAD_W-1:0]  rad  [NSTG];
  logic [SIDE_W-1:0] side [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic              v_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] rt_i;
    logic [RAD_W-1:0]  rad_i;
    logic [SIDE_W-1:0] side_i;
    logic [REM_W-1:0]  rem_n;
    logic [ROOT_W-1:0] rt_n;
    logic [RAD_W-1:0]  rad_n;

    if (s == 0) begin : g_first
      assign v_i    = valid_in;
      assign rem_i  = '0;
      assign rt_i   = '0;
      assign rad_i  = radicand;
      assign side_i = side_in;
    end else begin : g_rest
      assign v_i    = vld[s-1];
      assign rem_i  = rem[s-1];
      assign rt_i   = rt[s-1];
      assign rad_i  = rad[s-1];
      assign side_i = side[s-1];
    end

    always_comb begin
      logic [REM_W+1:0] t;
      logic [REM_W+1:0] trial;
      rem_n = rem_i;
      rt_n  = rt_i;
      rad_n = rad_i;
      for (int j = 0; j < 2; j++) begin
        t     = {rem_n, rad_n[RAD_W-1:RAD_W-2]};
        rad_n = rad_n << 2;
        trial = (REM_W+2)'({rt_n, 2'b01});
        if (t >= trial) begin
          rem_n = REM_W'(t - trial);
          rt_n  = {rt_n[ROOT_W-2:0], 1'b1};
        end else begin
          rem_n = t[REM_W-1:0];
          rt_n  = {rt_n[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= rem_n;
        rt[s]   <= rt_n;
        rad[s]  <= rad_n;
        side[s] <= side_i;
      end
    end
  end

  assign valid_out = vld[NSTG-1];
  assign root      = rt[NSTG-1];
  assign side_out  = side[NSTG-1];

endmodule

// ===== design/lscs_div.sv =====
`timescale 1ns / 1ps
module lscs_div #(
  parameter int STEPS  = 31,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [lscs_pkg::ROOT_W-1:0]   rem_in,
  input  logic [STEPS-1:0]              bits_in,
  input  logic [lscs_pkg::ROOT_W-1:0]   divisor,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          valid_out,
  output logic [STEPS-1:0]              quot,
  output logic [SIDE_W-1:0]             side_out
);
  import lscs_pkg::*;

  // Restoring division, up to two quotient bits per stage. The partial
  // remainder entering must already be below the divisor.
  localparam int NSTG = (STEPS + 1) / 2;

  logic              vld  [NSTG];
  logic [ROOT_W-1:0] rem  [NSTG];
  logic [STEPS-1:0]  bts  [NSTG];
  logic [STEPS-1:0]  quo  [NSTG];
  logic [ROOT_W-1:0] dvs  [NSTG];
  logic [SIDE_W-1:0] side [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic              v_i;
    logic [ROOT_W-1:0] rem_i;
    logic [STEPS-1:0]  bts_i;
    logic [STEPS-1:0]  quo_i;
    logic [ROOT_W-1:0] dvs_i;
    logic [SIDE_W-1:0] side_i;
    logic [ROOT_W-1:0] rem_n;
    logic [STEPS-1:0]  bts_n;
    logic [STEPS-1:0]  quo_n;

    if (s == 0) begin : g_first
      assign v_i    = valid_in;
      assign rem_i  = rem_in;
      assign bts_i  = bits_in;
      assign quo_i  = '0;
      assign dvs_i  = divisor;
      assign side_i = side_in;
    end else begin : g_rest
      assign v_i    = vld[s-1];
      assign rem_i  = rem[s-1];
      assign bts_i  = bts[s-1];
      assign quo_i  = quo[s-1];
      assign dvs_i  = dvs[s-1];
      assign side_i = side[s-1];
    end

    always_comb begin
      logic [ROOT_W:0] t;
      rem_n = rem_i;
      bts_n = bts_i;
      quo_n = quo_i;
      t     = '0;
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < STEPS) begin
          t     = {rem_n, bts_n[STEPS-1]};
          bts_n = bts_n << 1;
          if (t >= {1'b0, dvs_i}) begin
            rem_n = ROOT_W'(t - {1'b0, dvs_i});
            quo_n = {quo_n[STEPS-2:0], 1'b1};
          end else begin
            rem_n = t[ROOT_W-1:0];
            quo_n = {quo_n[STEPS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= rem_n;
        bts[s]  <= bts_n;
        quo[s]  <= quo_n;
        dvs[s]  <= dvs_i;
        side[s] <= side_i;
      end
    end
  end

  assign valid_out = vld[NSTG-1];
  assign quot      = quo[NSTG-1];
  assign side_out  = side[NSTG-1];

endmodule

// ===== design/level_set_curvature_stencil_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// in_ch     in   valid/ready        nine signed SAMPLE_BITS samples of a 3x3 window
// out_ch    out  valid/ready        curvature_out (Q16.16), flat_gradient
// cfg       in   cfg_we only        cfg_index, cfg_wdata (32 bits)
//
// One request is taken per cycle while out_ch is not stalled; each gives one result.
// Most of the pipeline's depth lies in three digit-by-digit units: square root,
// normal division and curvature division, each 16 stages of up to two bits.
// Reset is synchronous; it resets the configuration registers and every valid bit.
// A stall on out_ch freezes the whole pipeline; in_ch.ready falls with it.
module level_set_curvature_stencil_core #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  lscs_in_if.sink                         in_ch,
  lscs_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lscs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lscs_pkg::REG_W-1:0]      cfg_wdata
);
  import lscs_pkg::*;

  // Differences of up to four samples need two extra bits.
  localparam int D_W = SAMPLE_BITS + 2;

  // Configuration registers.
  logic [REG_W-1:0] inv_dx_x;
  logic [REG_W-1:0] inv_dx_y;
  logic [REG_W-1:0] curv_limit;
  logic [REG_W-1:0] min_gradient;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_dx_x     <= INV_DX_RESET;
      inv_dx_y     <= INV_DX_RESET;
      curv_limit   <= MAX_CURV_RESET;
      min_gradient <= MIN_GRAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_DX_X:     inv_dx_x     <= cfg_wdata;
        CFG_INV_DX_Y:     inv_dx_y     <= cfg_wdata;
        CFG_CURV_LIMIT:   curv_limit   <= cfg_wdata;
        CFG_MIN_GRADIENT: min_gradient <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Scale factors for the second derivatives. They are registered products of
  // the configuration registers and follow a register write in the next cycle.
  logic [K_W-1:0] k_x;
  logic [K_W-1:0] k_y;
  logic [K_W-1:0] k_xx;
  logic [K_W-1:0] k_yy;
  logic [K_W-1:0] k_xy;

  assign k_x = K_W'(inv_dx_x);
  assign k_y = K_W'(inv_dx_y);

  always_ff @(posedge clk) begin
    k_xx <= inv_dx_x * inv_dx_x;
    k_yy <= inv_dx_y * inv_dx_y;
    k_xy <= inv_dx_x * inv_dx_y;
  end

  // The pipeline moves as one whenever the output register is free or
  // being emptied.
  logic en;
  logic vout;

  assign en          = !vout || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: central differences.
  logic signed [D_W-1:0] sc, se, sw, sn, ss, sne, sse, snw, ssw;

  assign sc  = D_W'(in_ch.phi_center);
  assign se  = D_W'(in_ch.phi_east);
  assign sw  = D_W'(in_ch.phi_west);
  assign sn  = D_W'(in_ch.phi_north);
  assign ss  = D_W'(in_ch.phi_south);
  assign sne = D_W'(in_ch.phi_northeast);
  assign sse = D_W'(in_ch.phi_southeast);
  assign snw = D_W'(in_ch.phi_northwest);
  assign ssw = D_W'(in_ch.phi_southwest);

  logic                  v1;
  logic                  cpos1;
  logic signed [D_W-1:0] d_x, d_y, d_xx, d_yy, d_xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpos1 <= !in_ch.phi_center[SAMPLE_BITS-1] && (in_ch.phi_center != '0);
      d_x   <= se - sw;
      d_y   <= sn - ss;
      d_xx  <= se + sw - (sc <<< 1);
      d_yy  <= sn + ss - (sc <<< 1);
      d_xy  <= sne - sse - snw + ssw;
    end
  end

  // Stages 2 and 3: scaling by the reciprocal widths, truncated and saturated.
  logic signed [DERIV_W-1:0] px, py, pxx, pyy, pxy;

  lscs_scale #(.D_W(D_W), .SHIFT(17)) u_px (
    .clk(clk), .en(en), .d(d_x), .k(k_x), .q(px));
  lscs_scale #(.D_W(D_W), .SHIFT(17)) u_py (
    .clk(clk), .en(en), .d(d_y), .k(k_y), .q(py));
  lscs_scale #(.D_W(D_W), .SHIFT(32)) u_pxx (
    .clk(clk), .en(en), .d(d_xx), .k(k_xx), .q(pxx));
  lscs_scale #(.D_W(D_W), .SHIFT(32)) u_pyy (
    .clk(clk), .en(en), .d(d_yy), .k(k_yy), .q(pyy));
  lscs_scale #(.D_W(D_W), .SHIFT(34)) u_pxy (
    .clk(clk), .en(en), .d(d_xy), .k(k_xy), .q(pxy));

  logic v2, v3, cpos2, cpos3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpos2 <= cpos1;
      cpos3 <= cpos2;
    end
  end

  // Stage 4: gradient magnitudes and their squares.
  logic [DERIV_W-1:0] ax_c, ay_c;

  assign ax_c = px[DERIV_W-1] ? DERIV_W'(-px) : DERIV_W'(px);
  assign ay_c = py[DERIV_W-1] ? DERIV_W'(-py) : DERIV_W'(py);

  logic                      v4, cpos4, sd4;
  logic [DERIV_W-1:0]        ax4, ay4;
  logic [RAD_W-1:0]          sqx4, sqy4;
  logic signed [DERIV_W-1:0] pxx4, pyy4, pxy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpos4 <= cpos3;
      sd4   <= px[DERIV_W-1] ^ py[DERIV_W-1];
      ax4   <= ax_c;
      ay4   <= ay_c;
      sqx4  <= ax_c * ax_c;
      sqy4  <= ay_c * ay_c;
      pxx4  <= pxx;
      pyy4  <= pyy;
      pxy4  <= pxy;
    end
  end

  // Stage 5: squared gradient magnitude.
  logic                      v5, cpos5, sd5;
  logic [DERIV_W-1:0]        ax5, ay5;
  logic [RAD_W-1:0]          rad5;
  logic signed [DERIV_W-1:0] pxx5, pyy5, pxy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpos5 <= cpos4;
      sd5   <= sd4;
      ax5   <= ax4;
      ay5   <= ay4;
      rad5  <= sqx4 + sqy4;
      pxx5  <= pxx4;
      pyy5  <= pyy4;
      pxy5  <= pxy4;
    end
  end

  // Square root: g = floor(sqrt(px^2 + py^2)).
  localparam int SQ_SIDE_W = 2 * DERIV_W + 1 + 3 * DERIV_W + 1;

  logic                      v_sq, cpos_sq, sd_sq;
  logic [ROOT_W-1:0]         g_sq;
  logic [DERIV_W-1:0]        ax_sq, ay_sq;
  logic signed [DERIV_W-1:0] pxx_sq, pyy_sq, pxy_sq;
  logic [SQ_SIDE_W-1:0]      sq_side_out;

  lscs_isqrt #(.SIDE_W(SQ_SIDE_W)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v5),
    .radicand  (rad5),
    .side_in   ({ax5, ay5, sd5, pxx5, pyy5, pxy5, cpos5}),
    .valid_out (v_sq),
    .root      (g_sq),
    .side_out  (sq_side_out)
  );

  assign {ax_sq, ay_sq, sd_sq, pxx_sq, pyy_sq, pxy_sq, cpos_sq} = sq_side_out;

  // Unit normal components: n = |p| * 2^30 / g. Since |p| <= g, the
  // quotient fits in 31 bits and half of |p| is a valid starting remainder.
  // A zero g only occurs on the flat path, whose quotient is not used.
  localparam int NX_SIDE_W = ROOT_W + 3 * DERIV_W + 1;

  logic                      v_nx, cpos_nx, sd_ny;
  logic [NRM_W-1:0]          nx, ny;
  logic [ROOT_W-1:0]         g_nx;
  logic signed [DERIV_W-1:0] pxx_nx, pyy_nx, pxy_nx;
  logic [NX_SIDE_W-1:0]      nx_side_out;

  lscs_div #(.STEPS(NRM_W), .SIDE_W(NX_SIDE_W)) u_div_nx (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v_sq),
    .rem_in    ({1'b0, ax_sq[DERIV_W-1:1]}),
    .bits_in   ({ax_sq[0], (NRM_W-1)'(0)}),
    .divisor   (g_sq),
    .side_in   ({g_sq, pxx_sq, pyy_sq, pxy_sq, cpos_sq}),
    .valid_out (v_nx),
    .quot      (nx),
    .side_out  (nx_side_out)
  );

  assign {g_nx, pxx_nx, pyy_nx, pxy_nx, cpos_nx} = nx_side_out;

  lscs_div #(.STEPS(NRM_W), .SIDE_W(1)) u_div_ny (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v_sq),
    .rem_in    ({1'b0, ay_sq[DERIV_W-1:1]}),
    .bits_in   ({ay_sq[0], (NRM_W-1)'(0)}),
    .divisor   (g_sq),
    .side_in   (sd_sq),
    .valid_out (),
    .quot      (ny),
    .side_out  (sd_ny)
  );

  // Stage 7: products of normal components, back to Q2.30.
  logic [2*NRM_W-1:0] mxx, myy, mxy;

  assign mxx = nx * nx;
  assign myy = ny * ny;
  assign mxy = nx * ny;

  logic                      v7, cpos7, sd7;
  logic [ROOT_W-1:0]         g7;
  logic [31:0]               nxx7, nyy7, nxy7;
  logic signed [DERIV_W-1:0] pxx7, pyy7, pxy7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpos7 <= cpos_nx;
      sd7   <= sd_ny;
      g7    <= g_nx;
      nxx7  <= mxx[2*NRM_W-1:30];
      nyy7  <= myy[2*NRM_W-1:30];
      nxy7  <= mxy[2*NRM_W-1:30];
      pxx7  <= pxx_nx;
      pyy7  <= pyy_nx;
      pxy7  <= pxy_nx;
    end
  end

  // Stage 8: the three terms of the numerator, exact.
  logic signed [64:0] m1, m2, m3;

  assign m1 = $signed({1'b0, nxx7}) * pyy7;
  assign m2 = $signed({1'b0, nxy7}) * pxy7;
  assign m3 = $signed({1'b0, nyy7}) * pxx7;

  logic              v8, cpos8, sd8;
  logic [ROOT_W-1:0] g8;
  logic [63:0]       p1, p2, p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpos8 <= cpos7;
      sd8   <= sd7;
      g8    <= g7;
      p1    <= m1[63:0];
      p2    <= m2[63:0];
      p3    <= m3[63:0];
    end
  end

  // Stage 9: numerator sum. The mixed term changes sign when px and py
  // differ in sign. Arithmetic wraps at 64 bits.
  logic [63:0] p2x2;

  assign p2x2 = {p2[62:0], 1'b0};

  logic              v9, cpos9;
  logic [ROOT_W-1:0] g9;
  logic [63:0]       t9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpos9 <= cpos8;
      g9    <= g8;
      t9    <= sd8 ? (p1 + p2x2 + p3) : (p1 - p2x2 + p3);
    end
  end

  // Stage 10: magnitude of the numerator and the overflow test. Dividing
  // |t| by g * 2^14 is the same as dividing |t| >> 14 by g; the quotient
  // reaches 2^32 exactly when the bits above those 32 are at least g.
  logic [63:0] tm_c;

  assign tm_c = t9[63] ? (64'd0 - t9) : t9;

  logic              v10, cpos10, tneg10, ovf10;
  logic [ROOT_W-1:0] g10;
  logic [63:0]       tm10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpos10 <= cpos9;
      tneg10 <= t9[63];
      ovf10  <= ROOT_W'(tm_c[63:46]) >= g9;
      g10    <= g9;
      tm10   <= tm_c;
    end
  end

  // Curvature quotient, 32 bits.
  localparam int Q_SIDE_W = ROOT_W + 3;

  logic                v_q, cpos_q, tneg_q, ovf_q;
  logic [ROOT_W-1:0]   g_q;
  logic [CURV_W-1:0]   quo;
  logic [Q_SIDE_W-1:0] q_side_out;

  lscs_div #(.STEPS(CURV_W), .SIDE_W(Q_SIDE_W)) u_div_q (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v10),
    .rem_in    (ROOT_W'(tm10[63:46])),
    .bits_in   (tm10[45:14]),
    .divisor   (g10),
    .side_in   ({g10, ovf10, tneg10, cpos10}),
    .valid_out (v_q),
    .quot      (quo),
    .side_out  (q_side_out)
  );

  assign {g_q, ovf_q, tneg_q, cpos_q} = q_side_out;

  // Output stage: flat-gradient fallback, clamp to the curvature limit and
  // saturation to the signed 32-bit range.
  logic              flat_c;
  logic              neg_c;
  logic [CURV_W-1:0] mag_c;
  logic [CURV_W-1:0] curv_c;

  always_comb begin
    flat_c = (g_q == '0) || (g_q < min_gradient);
    if (flat_c) begin
      mag_c = curv_limit;
      neg_c = !cpos_q;
    end else begin
      mag_c = (ovf_q || (quo > curv_limit)) ? curv_limit : quo;
      neg_c = !tneg_q;
    end
    if (neg_c) begin
      curv_c = (mag_c > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag_c);
    end else begin
      curv_c = mag_c[CURV_W-1] ? 32'h7fff_ffff : mag_c;
    end
  end

  logic              flat_r;
  logic [CURV_W-1:0] curv_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flat_r <= flat_c;
      curv_r <= curv_c;
    end
  end

  assign out_ch.valid         = vout;
  assign out_ch.curvature_out = curv_r;
  assign out_ch.flat_gradient = flat_r;

endmodule

// ===== bench/tb_level_set_curvature_stencil_core.sv =====
`timescale 1ns / 1ps
module tb_level_set_curvature_stencil_core;
  import lscs_pkg::*;

  localparam int SB = 24;
  localparam int PIPE_DEPTH = 70;        // above the core's pipeline depth; leave headroom
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 256;
  localparam int NUM_PHASES = 6;
  localparam logic signed [SB-1:0] PMAX = 24'sh7FFFFF;
  localparam logic signed [SB-1:0] PMIN = 24'sh800000;

  // A 3x3 window in the order center, E, W, N, S, NE, SE, NW, SW.
  typedef logic signed [SB-1:0] window_t [0:8];

  typedef struct {
    window_t            win;
    bit                 typed;   // expected result written in below
    logic signed [31:0] curv;
    logic               flat;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] curv;
    logic               flat;
  } curv_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_wdata;

  lscs_in_if #(.SAMPLE_BITS(SB)) in_ch ();
  lscs_out_if out_ch ();

  level_set_curvature_stencil_core #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Register shadows that the curvature predictor works from.
  logic [31:0] sh_inv_dx_x, sh_inv_dx_y, sh_max_curv, sh_min_grad;

  curv_result_t curv_expected [$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // A generous cap on the whole run. A hang ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL level_set_curvature_stencil_core");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // d*k/2^sh truncated toward zero, then saturated to 32 bits signed.
  function automatic longint scaled_deriv(input longint d, input logic [63:0] k, input int sh);
    logic [63:0] ad;
    logic [127:0] prod;
    logic [63:0] mag;
    ad = (d < 0) ? 64'(-d) : 64'(d);
    prod = (128'(ad) * 128'(k)) >> sh;
    mag = (prod > 128'(64'd1 << 31)) ? (64'd1 << 31) : prod[63:0];
    if (d < 0) return -longint'(mag);
    return (mag > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(mag);
  endfunction

  function automatic logic [63:0] grad_root(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic curv_result_t predict_curvature(input window_t w);
    curv_result_t res;
    longint c, px, py, pxx, pyy, pxy, kv;
    logic [63:0] ax, ay, g, nxm, nym, nxx, nyy, nxy, t, tm, q;
    bit flat;
    c = longint'(w[0]);
    px = scaled_deriv(longint'(w[1]) - longint'(w[2]), 64'(sh_inv_dx_x), 17);
    py = scaled_deriv(longint'(w[3]) - longint'(w[4]), 64'(sh_inv_dx_y), 17);
    pxx = scaled_deriv(longint'(w[1]) - 2 * c + longint'(w[2]),
                       64'(sh_inv_dx_x) * 64'(sh_inv_dx_x), 32);
    pyy = scaled_deriv(longint'(w[3]) - 2 * c + longint'(w[4]),
                       64'(sh_inv_dx_y) * 64'(sh_inv_dx_y), 32);
    pxy = scaled_deriv(longint'(w[5]) - longint'(w[6]) - longint'(w[7]) + longint'(w[8]),
                       64'(sh_inv_dx_x) * 64'(sh_inv_dx_y), 34);
    ax = (px < 0) ? 64'(-px) : 64'(px);
    ay = (py < 0) ? 64'(-py) : 64'(py);
    g = grad_root(ax * ax + ay * ay);
    flat = (g == 0) || (g < 64'(sh_min_grad));
    if (flat) begin
      kv = (c > 0) ? longint'(sh_max_curv) : -longint'(sh_max_curv);
    end else begin
      // Unit normal in Q2.30, then the tangential second derivative, all mod 2^64.
      nxm = (ax << 30) / g;
      nym = (ay << 30) / g;
      nxx = (nxm * nxm) >> 30;
      nyy = (nym * nym) >> 30;
      nxy = (nxm * nym) >> 30;
      if ((px < 0) != (py < 0)) nxy = 64'd0 - nxy;
      t = nxx * 64'(pyy) - 64'd2 * nxy * 64'(pxy) + nyy * 64'(pxx);
      tm = t[63] ? 64'd0 - t : t;
      q = tm / (g << 14);
      if (q > 64'(sh_max_curv)) q = 64'(sh_max_curv);
      kv = t[63] ? longint'(q) : -longint'(q);
    end
    if (kv > 64'sh7FFF_FFFF) kv = 64'sh7FFF_FFFF;
    if (kv < -64'sh8000_0000) kv = -64'sh8000_0000;
    res.curv = kv[31:0];
    res.flat = flat;
    return res;
  endfunction

  // Only called with the pipeline empty.
  task automatic write_regs(input logic [31:0] vals [0:3]);
    logic [CFG_IDX_W-1:0] idx [0:3];
    idx = '{CFG_INV_DX_X, CFG_INV_DX_Y, CFG_CURV_LIMIT, CFG_MIN_GRADIENT};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_inv_dx_x = vals[0];
    sh_inv_dx_y = vals[1];
    sh_max_curv = vals[2];
    sh_min_grad = vals[3];
  endtask

  // Offers one request, with random idle cycles ahead of it, and records what
  // the core must return for it once it is taken.
  task automatic send_window(input window_t w, input bit typed,
                             input curv_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.phi_center <= w[0];
    in_ch.phi_east <= w[1];
    in_ch.phi_west <= w[2];
    in_ch.phi_north <= w[3];
    in_ch.phi_south <= w[4];
    in_ch.phi_northeast <= w[5];
    in_ch.phi_southeast <= w[6];
    in_ch.phi_northwest <= w[7];
    in_ch.phi_southwest <= w[8];
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    curv_expected.push_back(typed ? want : predict_curvature(w));
  endtask

  // The result side stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted result is checked against the oldest outstanding request.
  always @(posedge clk) begin
    curv_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (curv_expected.size() == 0) begin
        report("unexpected result", out_ch.curvature_out, 0);
      end else begin
        want = curv_expected.pop_front();
        if (out_ch.curvature_out !== want.curv)
          report("curvature_out", out_ch.curvature_out, want.curv);
        if (out_ch.flat_gradient !== want.flat)
          report("flat_gradient", out_ch.flat_gradient, want.flat);
      end
    end
  end

  initial begin
    stim_row_t dir_tab [$];
    logic [31:0] cfg_vals [0:3];
    window_t w;
    curv_result_t none;
    int gx, gy, ax2, by2, cxy, base, kind;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_INV_DX_X;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    {in_ch.phi_center, in_ch.phi_east, in_ch.phi_west} <= '0;
    {in_ch.phi_north, in_ch.phi_south, in_ch.phi_northeast} <= '0;
    {in_ch.phi_southeast, in_ch.phi_northwest, in_ch.phi_southwest} <= '0;
    sh_inv_dx_x = INV_DX_RESET;
    sh_inv_dx_y = INV_DX_RESET;
    sh_max_curv = MAX_CURV_RESET;
    sh_min_grad = MIN_GRAD_RESET;
    none = '{curv: '0, flat: 1'b0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed requests, run with the reset register values. A constant window
    // has no gradient, so it takes the flat case with the sign of the center;
    // a zero center counts as negative.
    dir_tab = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, -32'sd65536, 1'b1},
      '{'{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}, 1, 32'sd65536, 1'b1},
      '{'{PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN}, 1, -32'sd65536, 1'b1},
      '{'{1, 1, 1, 1, 1, 1, 1, 1, 1}, 1, 32'sd65536, 1'b1},
      // A one-LSB slope truncates to a zero derivative: still flat.
      '{'{0, 1, 0, 0, 0, 0, 0, 0, 0}, 1, -32'sd65536, 1'b1},
      // A two-LSB slope gives a gradient of exactly the threshold.
      '{'{0, 2, 0, 0, 0, 0, 0, 0, 0}, 0, 0, 0},
      '{'{0, PMAX, PMIN, 0, 0, 0, 0, 0, 0}, 0, 0, 0},
      '{'{0, PMIN, PMAX, 0, 0, 0, 0, 0, 0}, 0, 0, 0},
      '{'{0, 0, 0, PMAX, PMIN, 0, 0, 0, 0}, 0, 0, 0},
      '{'{0, 1, 0, 0, 0, PMAX, PMIN, PMIN, PMAX}, 0, 0, 0},
      '{'{PMAX, PMAX, PMIN, PMIN, PMAX, PMIN, PMAX, PMAX, PMIN}, 0, 0, 0},
      '{'{PMIN, PMIN, PMAX, PMAX, PMIN, PMAX, PMIN, PMIN, PMAX}, 0, 0, 0},
      '{'{100000, 200000, 10000, 150000, 60000, 260000, 170000, 60000, -20000}, 0, 0, 0},
      '{'{-100000, -200000, -10000, -150000, -60000, -260000, -170000, -60000, 20000},
        0, 0, 0},
      '{'{0, 65536, -65536, 65536, -65536, 131072, 0, 0, -131072}, 0, 0, 0},
      '{'{-3, 70000, -70000, -9000, 9000, 1000, -1000, -1000, 1000}, 0, 0, 0}
    };
    foreach (dir_tab[i])
      send_window(dir_tab[i].win, dir_tab[i].typed,
                  '{curv: dir_tab[i].curv, flat: dir_tab[i].flat});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        // Let the pipeline drain before touching the registers.
        in_ch.valid <= 1'b0;
        while (curv_expected.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
        case (ph)
          1: cfg_vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0};
          2: cfg_vals = '{32'd1, 32'd1, 32'd0, 32'hFFFF_FFFF};
          3: cfg_vals = '{32'd0, 32'd65536, 32'h7FFF_FFFF, 32'd0};
          4: cfg_vals = '{$urandom_range(1 << 20, 1 << 12), $urandom_range(1 << 20, 1 << 12),
                          $urandom, $urandom_range(4096, 0)};
          default: cfg_vals = '{32'd32768, 32'd131072, 32'h8000_0000, 32'd2};
        endcase
        write_regs(cfg_vals);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 67; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(9);
        if (kind < 3) begin
          // Raw noise: every sample bit toggles.
          foreach (w[k]) w[k] = SB'($urandom);
        end else begin
          // A smooth quadratic surface, the shape a real level set has.
          base = $urandom_range(1 << 22) - (1 << 21);
          gx = $urandom_range(1 << 17) - (1 << 16);
          gy = $urandom_range(1 << 17) - (1 << 16);
          ax2 = $urandom_range(1 << 15) - (1 << 14);
          by2 = $urandom_range(1 << 15) - (1 << 14);
          cxy = $urandom_range(1 << 14) - (1 << 13);
          if (kind == 9) begin
            gx = gx >>> 12;
            gy = gy >>> 12;
          end
          w[0] = SB'(base);
          w[1] = SB'(base + gx + ax2);
          w[2] = SB'(base - gx + ax2);
          w[3] = SB'(base + gy + by2);
          w[4] = SB'(base - gy + by2);
          w[5] = SB'(base + gx + gy + ax2 + by2 + cxy);
          w[6] = SB'(base + gx - gy + ax2 + by2 - cxy);
          w[7] = SB'(base - gx + gy + ax2 + by2 - cxy);
          w[8] = SB'(base - gx - gy + ax2 + by2 + cxy);
        end
        send_window(w, 1'b0, none);
      end
    end
    in_ch.valid <= 1'b0;

    while (curv_expected.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    if (errors == 0) begin
      $display("PASS level_set_curvature_stencil_core");
    end else begin
      $display("FAIL level_set_curvature_stencil_core");
    end
    $finish;
  end

endmodule
